### src/hsfs_pkg.sv
// package for the scaled hmm forward step
// shared types, codes and defaults; no dependencies
`timescale 1ns / 1ps

package hsfs_pkg;

  // default number of hidden states
  localparam int unsigned NSTATES_DEF = 8;

  // probability 1.0 in unsigned q1.31
  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  // restoring divider produces one quotient bit per step
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  // request opcodes
  typedef enum logic [1:0] {
    OP_TRANS = 2'd0,
    OP_INIT  = 2'd1,
    OP_LIKE  = 2'd2,
    OP_START = 2'd3
  } op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_TMUL,
    ST_ACC,
    ST_RMUL,
    ST_RWR,
    ST_CHECK,
    ST_DRD,
    ST_DINIT,
    ST_DIV,
    ST_OUT,
    ST_ERR
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic wr_en;      // store an accepted load request
    logic set_first;
    logic clr_first;
    logic rst_i;
    logic inc_i;
    logic rst_s;
    logic inc_s;
    logic clr_acc;
    logic mul_tp;     // previous forward times transition entry
    logic acc_add;
    logic mul_raw;    // likelihood times multiplier
    logic raw_wr;
    logic clr_tot;
    logic div_init;
    logic div_step;
    logic prev_wr;
    logic show_err;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic first;
    logic i_last;
    logic s_last;
    logic tot_zero;
    logic div_done;
  } sts_t;

endpackage

### src/hsfs_ctrl.sv
// controller state machine for the scaled hmm forward step
// depends on hsfs_pkg
`timescale 1ns / 1ps

module hsfs_ctrl import hsfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (op_e'(op_i) == OP_START) begin
            cmd_o.set_first = 1'b1;
          end
          if (op_e'(op_i) == OP_LIKE && last_i) begin
            cmd_o.rst_i   = 1'b1;
            cmd_o.rst_s   = 1'b1;
            cmd_o.clr_acc = 1'b1;
            cmd_o.clr_tot = 1'b1;
            state_d       = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = sts_i.first ? ST_RMUL : ST_TMUL;
      end
      ST_TMUL: begin
        cmd_o.mul_tp = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (sts_i.s_last) begin
          cmd_o.rst_s = 1'b1;
          state_d     = ST_RMUL;
        end else begin
          cmd_o.inc_s = 1'b1;
          state_d     = ST_RD;
        end
      end
      ST_RMUL: begin
        cmd_o.mul_raw = 1'b1;
        state_d       = ST_RWR;
      end
      ST_RWR: begin
        cmd_o.raw_wr  = 1'b1;
        cmd_o.clr_acc = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.rst_i = 1'b1;
          state_d     = ST_CHECK;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d     = ST_RD;
        end
      end
      ST_CHECK: begin
        state_d = sts_i.tot_zero ? ST_ERR : ST_DRD;
      end
      ST_DRD: begin
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.prev_wr = 1'b1;
          if (sts_i.i_last) begin
            cmd_o.clr_first = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.inc_i = 1'b1;
            state_d     = ST_DRD;
          end
        end
      end
      ST_ERR: begin
        out_valid_o    = 1'b1;
        cmd_o.show_err = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/hsfs_dp.sv
// datapath for the scaled hmm forward step: tables, shared multiplier,
// accumulators and a restoring divider; depends on hsfs_pkg
`timescale 1ns / 1ps

module hsfs_dp import hsfs_pkg::*; #(
  parameter int unsigned NSTATES = NSTATES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  src_index_i,
  input  logic [2:0]  dst_index_i,
  input  logic [31:0] value_i,
  output logic [31:0] forward_value_o,
  output logic [2:0]  state_index_o,
  output logic [31:0] norm_sum_o,
  output logic        error_o,
  output logic        last_out_o
);

  localparam int unsigned IW    = $clog2(NSTATES);
  localparam int unsigned TDEP  = NSTATES * NSTATES;
  localparam int unsigned TAW   = $clog2(TDEP);
  localparam int unsigned ACC_W = 32 + $clog2(NSTATES);
  localparam int unsigned TOT_W = 32 + $clog2(NSTATES);

  // storage
  logic [31:0] trans_mem [TDEP];
  logic [31:0] init_mem  [NSTATES];
  logic [31:0] like_mem  [NSTATES];
  logic [31:0] prev_mem  [NSTATES];
  logic [31:0] raw_mem   [NSTATES];

  logic [31:0] trans_rd_q, init_rd_q, like_rd_q, prev_rd_q, raw_rd_q;

  logic [IW-1:0]     i_q, s_q;
  logic              first_q;
  logic [63:0]       prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic [TOT_W-1:0]  tot_q;
  logic [TOT_W-1:0]  rem_q;
  logic [31:0]       dlow_q;
  logic [31:0]       quo_q;
  logic [DIV_CW-1:0] dcnt_q;

  // input decode
  logic [31:0]  val_sat;
  logic         src_ok, dst_ok;
  logic [IW-1:0] wr_src;
  logic [TAW-1:0] wr_taddr, rd_taddr;

  assign val_sat  = (value_i > Q_ONE) ? Q_ONE : value_i;
  assign src_ok   = 32'(src_index_i) < NSTATES;
  assign dst_ok   = 32'(dst_index_i) < NSTATES;
  assign wr_src   = IW'(32'(src_index_i));
  assign wr_taddr = TAW'(32'(src_index_i) * NSTATES + 32'(dst_index_i));
  assign rd_taddr = TAW'(32'(s_q) * NSTATES + 32'(i_q));

  // load writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      case (op_e'(op_i))
        OP_TRANS: if (src_ok && dst_ok) trans_mem[wr_taddr] <= val_sat;
        OP_INIT:  if (src_ok) init_mem[wr_src] <= val_sat;
        OP_LIKE:  if (src_ok) like_mem[wr_src] <= val_sat;
        default: ;
      endcase
    end
  end

  // registered table reads
  always_ff @(posedge clk_i) begin
    trans_rd_q <= trans_mem[rd_taddr];
    init_rd_q  <= init_mem[i_q];
    like_rd_q  <= like_mem[i_q];
    prev_rd_q  <= prev_mem[s_q];
    raw_rd_q   <= raw_mem[i_q];
  end

  // raw value and normalized value writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.raw_wr) begin
      raw_mem[i_q] <= prod_q[62:31];
    end
    if (cmd_i.prev_wr) begin
      prev_mem[i_q] <= quo_q;
    end
  end

  // state and source counters, first position flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      s_q     <= '0;
      first_q <= 1'b1;
    end else begin
      if (cmd_i.rst_i) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.rst_s) begin
        s_q <= '0;
      end else if (cmd_i.inc_s) begin
        s_q <= s_q + 1'b1;
      end
      if (cmd_i.set_first) begin
        first_q <= 1'b1;
      end else if (cmd_i.clr_first) begin
        first_q <= 1'b0;
      end
    end
  end

  // shared multiplier; second operand is the saturated accumulator, or the initial probability on the first position
  logic [31:0] mult;
  assign mult = first_q ? init_rd_q
              : (|acc_q[ACC_W-1:32] ? 32'hFFFF_FFFF : acc_q[31:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_tp) begin
      prod_q <= 64'(prev_rd_q) * 64'(trans_rd_q);
    end else if (cmd_i.mul_raw) begin
      prod_q <= 64'(like_rd_q) * 64'(mult);
    end
  end

  // sum over sources and total over states
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q[63:31]);
    end
    if (cmd_i.clr_tot) begin
      tot_q <= '0;
    end else if (cmd_i.raw_wr) begin
      tot_q <= tot_q + TOT_W'(prod_q[62:31]);
    end
  end

  // restoring divider, quotient of raw times 2^31 by the total
  logic [TOT_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, dlow_q[31]};
  assign rem_ge = rem_sh >= {1'b0, tot_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= TOT_W'(raw_rd_q[31:1]);
      dlow_q <= {raw_rd_q[0], 31'd0};
      quo_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? TOT_W'(rem_sh - {1'b0, tot_q}) : rem_sh[TOT_W-1:0];
      dlow_q <= {dlow_q[30:0], 1'b0};
      quo_q  <= {quo_q[30:0], rem_ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // status
  assign sts_o.first    = first_q;
  assign sts_o.i_last   = i_q == IW'(NSTATES - 1);
  assign sts_o.s_last   = s_q == IW'(NSTATES - 1);
  assign sts_o.tot_zero = tot_q == '0;
  assign sts_o.div_done = dcnt_q == DIV_CW'(DIV_STEPS - 1);

  // result fields
  logic [TOT_W-1:0] sf_wide;
  logic [31:0]      sf;
  assign sf_wide = tot_q >> 5;
  assign sf      = |sf_wide[TOT_W-1:32] ? 32'hFFFF_FFFF : sf_wide[31:0];

  assign forward_value_o = cmd_i.show_err ? 32'd0 : quo_q;
  assign state_index_o   = cmd_i.show_err ? 3'd0 : 3'(i_q);
  assign norm_sum_o      = cmd_i.show_err ? 32'd0 : sf;
  assign error_o         = cmd_i.show_err;
  assign last_out_o      = cmd_i.show_err | sts_o.i_last;

endmodule

### src/hmm_scaled_forward_step.sv
// Scaled hmm forward step. Load requests (transition entry, initial
// probability, likelihood element, start) are accepted while idle. A
// likelihood element marked last starts a position: the shared 32x32
// multiplier walks all states, summing over all source states except
// on the first position; the sum is then checked for zero, and a
// one-bit-per-cycle restoring divider produces each normalized value,
// which is held until the consumer takes it. No request is accepted
// while a position is in progress. A zero sum yields a single error result.
// depends on hsfs_pkg, hsfs_ctrl, hsfs_dp
`timescale 1ns / 1ps

module hmm_scaled_forward_step import hsfs_pkg::*; #(
  parameter int unsigned NSTATES = NSTATES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  src_index_i,
  input  logic [2:0]  dst_index_i,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] forward_value_o,
  output logic [2:0]  state_index_o,
  output logic [31:0] norm_sum_o,
  output logic        error_o,
  output logic        last_out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  hsfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  hsfs_dp #(
    .NSTATES (NSTATES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .src_index_i     (src_index_i),
    .dst_index_i     (dst_index_i),
    .value_i         (value_i),
    .forward_value_o (forward_value_o),
    .state_index_o   (state_index_o),
    .norm_sum_o      (norm_sum_o),
    .error_o         (error_o),
    .last_out_o      (last_out_o)
  );

endmodule
